@@ sv/jscd_pkg.sv @@
// jscd_pkg: types and constants shared by the json string code point decoder
// no dependencies; compiled first

package jscd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned GRP_W  = 16;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ESC  = 3'd1,
      PH_HEX1 = 3'd2,
      PH_SKIP = 3'd3,
      PH_HEX2 = 3'd4,
      PH_UTF8 = 3'd5
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              start_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
   } rsp_payload_type;

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;

   localparam logic [7:0] CC_BS  = 8'h08;
   localparam logic [7:0] CC_FF  = 8'h0C;
   localparam logic [7:0] CC_LF  = 8'h0A;
   localparam logic [7:0] CC_CR  = 8'h0D;
   localparam logic [7:0] CC_TAB = 8'h09;

   localparam logic [7:0] UTF8_LEAD2 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hF0;

   localparam logic [GRP_W-1:0] HI_SURR_LO = 16'hD800;
   localparam logic [GRP_W-1:0] HI_SURR_HI = 16'hDBFF;
   localparam logic [CP_W-1:0]  LO_SURR    = 21'h00DC00;
   localparam logic [CP_W-1:0]  SUPP_BASE  = 21'h010000;

   // hex digit value; anything but 0-9 and a-f takes byte minus 55 modulo 2^16
   function automatic logic [GRP_W-1:0] nibble_of(input logic [BYTE_W-1:0] b);
      logic [GRP_W-1:0] r;
      if (b inside {[8'h30:8'h39]}) begin
         r = {8'h00, b - 8'h30};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {8'h00, b - 8'h57};
      end else begin
         r = {8'h00, b} - 16'd55;
      end
      return r;
   endfunction

endpackage

@@ sv/jscd_if.sv @@
// jscd_req_if / jscd_rsp_if: valid-ready channels of the decoder
// depends on jscd_pkg for the payload types

interface jscd_req_if;
   logic                      valid;
   logic                      ready;
   jscd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface jscd_rsp_if;
   logic                      valid;
   logic                      ready;
   jscd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ sv/json_string_codepoint_decoder_core.sv @@
// Decodes a JSON string body, one byte per transaction, into Unicode code points:
// plain ASCII, backslash escapes, \u groups with surrogate pairs, and UTF-8
// sequences. A byte with start_of_string set drops any partial sequence first.
// A byte passes through the input register and then the result register, with a
// combinational decode of the phase, digit count and 21-bit value between them.
// One byte is taken per cycle while the result side accepts. A byte gives zero or
// one code point. No bubbles occur while the result side accepts.
// Depends on jscd_pkg and jscd_if.sv.

module json_string_codepoint_decoder_core (
   input  logic              clock,
   input  logic              reset,
   jscd_req_if.sink          req_chan,
   jscd_rsp_if.source        rsp_chan
);

   // input register
   logic                          in_valid_ff;
   logic [jscd_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_sos_ff;

   // decode state
   jscd_pkg::phase_type           phase_ff, phase_in;
   logic [1:0]                    digits_ff, digits_in;
   logic [jscd_pkg::CP_W-1:0]     acc_ff, acc_in;
   logic [jscd_pkg::GRP_W-1:0]    hsurr_ff, hsurr_in;

   // result register
   logic                          rsp_valid_ff;
   logic [jscd_pkg::CP_W-1:0]     rsp_cp_ff;

   logic                          advance;
   logic                          emit;
   logic [jscd_pkg::CP_W-1:0]     cp;

   jscd_pkg::phase_type           cur_phase;
   logic [1:0]                    cur_digits;
   logic [jscd_pkg::CP_W-1:0]     cur_acc;
   logic [jscd_pkg::GRP_W-1:0]    cur_hsurr;
   logic [jscd_pkg::GRP_W-1:0]    hex_val;
   logic [jscd_pkg::GRP_W-1:0]    hsurr_off;
   logic [1:0]                    lead_cnt;
   logic [7:0]                    lead_mask;

   assign advance          = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload.code_point = rsp_cp_ff;

   always_comb begin
      if (in_sos_ff) begin
         cur_phase  = jscd_pkg::PH_IDLE;
         cur_digits = 2'd0;
         cur_acc    = '0;
         cur_hsurr  = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_digits = digits_ff;
         cur_acc    = acc_ff;
         cur_hsurr  = hsurr_ff;
      end

      hex_val   = {cur_acc[11:0], 4'h0} | jscd_pkg::nibble_of(in_byte_ff);
      hsurr_off = cur_hsurr - jscd_pkg::HI_SURR_LO;

      if (in_byte_ff < jscd_pkg::UTF8_LEAD2) begin
         lead_cnt = 2'd1;
      end else if (in_byte_ff < jscd_pkg::UTF8_LEAD3) begin
         lead_cnt = 2'd2;
      end else begin
         lead_cnt = 2'd3;
      end
      lead_mask = 8'h7F >> lead_cnt;

      phase_in  = cur_phase;
      digits_in = cur_digits;
      acc_in    = cur_acc;
      hsurr_in  = cur_hsurr;
      emit      = 1'b0;
      cp        = '0;

      case (cur_phase)
         jscd_pkg::PH_ESC: begin
            phase_in = jscd_pkg::PH_IDLE;
            emit     = 1'b1;
            case (in_byte_ff)
               jscd_pkg::CH_QUOTE, jscd_pkg::CH_BACKSLASH, jscd_pkg::CH_SLASH:
                  cp = {13'd0, in_byte_ff};
               jscd_pkg::CH_B: cp = {13'd0, jscd_pkg::CC_BS};
               jscd_pkg::CH_F: cp = {13'd0, jscd_pkg::CC_FF};
               jscd_pkg::CH_N: cp = {13'd0, jscd_pkg::CC_LF};
               jscd_pkg::CH_R: cp = {13'd0, jscd_pkg::CC_CR};
               jscd_pkg::CH_T: cp = {13'd0, jscd_pkg::CC_TAB};
               default: begin
                  emit      = 1'b0;
                  phase_in  = jscd_pkg::PH_HEX1;
                  digits_in = 2'd3;
                  acc_in    = '0;
               end
            endcase
         end
         jscd_pkg::PH_HEX1: begin
            acc_in = {5'd0, hex_val};
            if (cur_digits != 2'd0) begin
               digits_in = cur_digits - 2'd1;
            end else if (hex_val >= jscd_pkg::HI_SURR_LO &&
                         hex_val <= jscd_pkg::HI_SURR_HI) begin
               hsurr_in  = hex_val;
               acc_in    = '0;
               phase_in  = jscd_pkg::PH_SKIP;
               digits_in = 2'd1;
            end else begin
               cp       = {5'd0, hex_val};
               emit     = 1'b1;
               phase_in = jscd_pkg::PH_IDLE;
            end
         end
         jscd_pkg::PH_SKIP: begin
            if (cur_digits != 2'd0) begin
               digits_in = cur_digits - 2'd1;
            end else begin
               phase_in  = jscd_pkg::PH_HEX2;
               digits_in = 2'd3;
               acc_in    = '0;
            end
         end
         jscd_pkg::PH_HEX2: begin
            acc_in = {5'd0, hex_val};
            if (cur_digits != 2'd0) begin
               digits_in = cur_digits - 2'd1;
            end else begin
               cp = jscd_pkg::SUPP_BASE + {hsurr_off[10:0], 10'd0}
                    + ({5'd0, hex_val} - jscd_pkg::LO_SURR);
               emit     = 1'b1;
               phase_in = jscd_pkg::PH_IDLE;
            end
         end
         jscd_pkg::PH_UTF8: begin
            acc_in = {cur_acc[14:0], in_byte_ff[5:0]};
            if (cur_digits != 2'd0) begin
               digits_in = cur_digits - 2'd1;
            end else begin
               cp       = {cur_acc[14:0], in_byte_ff[5:0]};
               emit     = 1'b1;
               phase_in = jscd_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = jscd_pkg::PH_IDLE;
            if (in_byte_ff == jscd_pkg::CH_BACKSLASH) begin
               phase_in = jscd_pkg::PH_ESC;
            end else if (!in_byte_ff[7]) begin
               cp   = {13'd0, in_byte_ff};
               emit = 1'b1;
            end else begin
               acc_in    = {13'd0, in_byte_ff & lead_mask};
               digits_in = lead_cnt - 2'd1;
               phase_in  = jscd_pkg::PH_UTF8;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= jscd_pkg::PH_IDLE;
         digits_ff    <= 2'd0;
         acc_ff       <= '0;
         hsurr_ff     <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff && emit;
         end
         if (in_valid_ff && advance) begin
            phase_ff  <= phase_in;
            digits_ff <= digits_in;
            acc_ff    <= acc_in;
            hsurr_ff  <= hsurr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.payload.in_byte;
         in_sos_ff  <= req_chan.payload.start_of_string;
      end
      if (advance && in_valid_ff && emit) begin
         rsp_cp_ff <= cp;
      end
   end

`ifndef SYNTHESIS
   // a held input byte is not lost while the result side stalls
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register dropped a byte under stall");

   // the skip phase counts two bytes only
   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jscd_pkg::PH_SKIP |-> digits_ff <= 2'd1)
      else $error("skip phase digit count out of range");

   // a stored high surrogate is in range while the pair is pending
   a_hsurr_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jscd_pkg::PH_SKIP || phase_ff == jscd_pkg::PH_HEX2 |->
      hsurr_ff >= jscd_pkg::HI_SURR_LO && hsurr_ff <= jscd_pkg::HI_SURR_HI)
      else $error("high surrogate out of range");

   // hex groups stay within 16 bits
   a_hex_width: assert property (@(posedge clock) disable iff (reset)
      phase_ff == jscd_pkg::PH_HEX1 || phase_ff == jscd_pkg::PH_HEX2 |->
      acc_ff[20:16] == 5'd0)
      else $error("hex group exceeds 16 bits");
`endif

endmodule

@@ test/tb_json_string_codepoint_decoder_core.sv @@
// tb_json_string_codepoint_decoder_core: self-checking testbench of the json string decoder
// drives byte transactions, predicts code points in its own decoder and checks every one
// depends on jscd_pkg, jscd_if.sv and json_string_codepoint_decoder_core

module tb_json_string_codepoint_decoder_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BYTES = 1000;
   localparam logic [7:0]  ESC_UNICODE  = 8'h75;
   localparam logic [7:0]  UTF8_CONT    = 8'h80;

   typedef struct {
      jscd_pkg::req_payload_type data;
      bit                        wait_drain;
   } pending_byte_type;

   logic clock;
   logic reset;

   jscd_req_if req_if ();
   jscd_rsp_if rsp_if ();

   json_string_codepoint_decoder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   pending_byte_type              pending_bytes[$];
   logic [jscd_pkg::CP_W-1:0]     predicted_cps[$];

   // decoder state of the predictor
   jscd_pkg::phase_type           dec_phase;
   logic [1:0]                    dec_digits;
   logic [jscd_pkg::CP_W-1:0]     dec_acc;
   logic [15:0]                   dec_hi_surr;

   int  n_errors = 0;
   int  n_bytes_sent = 0;
   int  n_cps_checked = 0;
   int  n_escapes = 0;
   int  n_surr_pairs = 0;
   int  n_utf8_seqs = 0;
   int  send_gap;
   int  send_gap_n;
   int  recv_gap;
   int  recv_gap_n;
   bit  src_quiet = 1'b0;
   bit  snk_quiet = 1'b0;
   bit  next_sos = 1'b0;
   logic long_hold = 1'b0;
   logic [jscd_pkg::CP_W-1:0] want_cp;

   task automatic flag_error(input string msg);
      $display("mismatch: %s", msg);
      n_errors++;
   endtask

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [15:0] digit_value(input logic [7:0] b);
      logic [15:0] v;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {8'h00, b} - 16'h0030;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = {8'h00, b} - 16'h0057;
      end else begin
         v = {8'h00, b} - 16'd55;
      end
      return v;
   endfunction

   task automatic clear_decoder();
      dec_phase   = jscd_pkg::PH_IDLE;
      dec_digits  = 2'd0;
      dec_acc     = '0;
      dec_hi_surr = '0;
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic sos);
      logic [31:0]               hi_ext;
      logic [31:0]               lo_ext;
      logic [31:0]               sum;
      logic [1:0]                cnt;
      logic [15:0]               grp;
      logic [jscd_pkg::CP_W-1:0] cp;
      bit                        emit;
      emit = 1'b0;
      cp = '0;
      if (sos) begin
         clear_decoder();
      end
      case (dec_phase)
         jscd_pkg::PH_ESC: begin
            dec_phase = jscd_pkg::PH_IDLE;
            emit = 1'b1;
            case (b)
               jscd_pkg::CH_QUOTE, jscd_pkg::CH_BACKSLASH, jscd_pkg::CH_SLASH:
                  cp = {13'd0, b};
               jscd_pkg::CH_B: cp = {13'd0, jscd_pkg::CC_BS};
               jscd_pkg::CH_F: cp = {13'd0, jscd_pkg::CC_FF};
               jscd_pkg::CH_N: cp = {13'd0, jscd_pkg::CC_LF};
               jscd_pkg::CH_R: cp = {13'd0, jscd_pkg::CC_CR};
               jscd_pkg::CH_T: cp = {13'd0, jscd_pkg::CC_TAB};
               default: begin
                  emit = 1'b0;
                  dec_phase = jscd_pkg::PH_HEX1;
                  dec_digits = 2'd3;
                  dec_acc = '0;
               end
            endcase
         end
         jscd_pkg::PH_HEX1: begin
            grp = {dec_acc[11:0], 4'h0} | digit_value(b);
            dec_acc = {5'd0, grp};
            if (dec_digits != 2'd0) begin
               dec_digits = dec_digits - 2'd1;
            end else if (grp >= jscd_pkg::HI_SURR_LO && grp <= jscd_pkg::HI_SURR_HI) begin
               dec_hi_surr = grp;
               dec_acc = '0;
               dec_phase = jscd_pkg::PH_SKIP;
               dec_digits = 2'd1;
            end else begin
               cp = dec_acc;
               emit = 1'b1;
               dec_phase = jscd_pkg::PH_IDLE;
            end
         end
         jscd_pkg::PH_SKIP: begin
            if (dec_digits != 2'd0) begin
               dec_digits = dec_digits - 2'd1;
            end else begin
               dec_phase = jscd_pkg::PH_HEX2;
               dec_digits = 2'd3;
               dec_acc = '0;
            end
         end
         jscd_pkg::PH_HEX2: begin
            grp = {dec_acc[11:0], 4'h0} | digit_value(b);
            dec_acc = {5'd0, grp};
            if (dec_digits != 2'd0) begin
               dec_digits = dec_digits - 2'd1;
            end else begin
               hi_ext = {16'd0, dec_hi_surr};
               lo_ext = {11'd0, dec_acc};
               sum = {11'd0, jscd_pkg::SUPP_BASE}
                     + ((hi_ext - {16'd0, jscd_pkg::HI_SURR_LO}) << 10)
                     + (lo_ext - {11'd0, jscd_pkg::LO_SURR});
               cp = sum[jscd_pkg::CP_W-1:0];
               emit = 1'b1;
               dec_phase = jscd_pkg::PH_IDLE;
            end
         end
         jscd_pkg::PH_UTF8: begin
            dec_acc = {dec_acc[jscd_pkg::CP_W-7:0], b[5:0]};
            if (dec_digits != 2'd0) begin
               dec_digits = dec_digits - 2'd1;
            end else begin
               cp = dec_acc;
               emit = 1'b1;
               dec_phase = jscd_pkg::PH_IDLE;
            end
         end
         default: begin
            dec_phase = jscd_pkg::PH_IDLE;
            if (b == jscd_pkg::CH_BACKSLASH) begin
               dec_phase = jscd_pkg::PH_ESC;
            end else if (b < UTF8_CONT) begin
               cp = {13'd0, b};
               emit = 1'b1;
            end else begin
               cnt = (b < jscd_pkg::UTF8_LEAD2) ? 2'd1 :
                     ((b < jscd_pkg::UTF8_LEAD3) ? 2'd2 : 2'd3);
               dec_acc = {13'd0, b & (8'h7F >> cnt)};
               dec_digits = cnt - 2'd1;
               dec_phase = jscd_pkg::PH_UTF8;
            end
         end
      endcase
      if (emit) begin
         predicted_cps.push_back(cp);
      end
   endtask

   // stimulus building
   task automatic put(input logic [7:0] b, input bit sos = 1'b0);
      pending_byte_type p;
      p.data.in_byte = b;
      p.data.start_of_string = sos | next_sos;
      p.wait_drain = 1'b0;
      next_sos = 1'b0;
      pending_bytes.push_back(p);
   endtask

   task automatic put_hex4(input logic [15:0] v, input bit noisy);
      logic [3:0] nib;
      logic [7:0] ch;
      int         bad_pos;
      bad_pos = noisy ? int'($urandom_range(0, 3)) : -1;
      for (int i = 3; i >= 0; i--) begin
         nib = v[i*4 +: 4];
         if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
         end else begin
            ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
         end
         if (i == bad_pos) begin
            ch = 8'($urandom_range(0, 255));
         end
         put(ch);
      end
   endtask

   function automatic logic [7:0] odd_escape_letter();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == jscd_pkg::CH_QUOTE || b == jscd_pkg::CH_BACKSLASH
                 || b == jscd_pkg::CH_SLASH || b == jscd_pkg::CH_B
                 || b == jscd_pkg::CH_F || b == jscd_pkg::CH_N
                 || b == jscd_pkg::CH_R || b == jscd_pkg::CH_T);
      return b;
   endfunction

   task automatic put_utf8();
      int         n;
      logic [7:0] lead;
      n = $urandom_range(2, 4);
      case (n)
         2: lead = 8'hC2 + 8'($urandom_range(0, 29));
         3: lead = jscd_pkg::UTF8_LEAD2 | 8'($urandom_range(0, 15));
         default: lead = jscd_pkg::UTF8_LEAD3 | 8'($urandom_range(0, 7));
      endcase
      put(lead);
      for (int i = 1; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            put(8'($urandom_range(0, 255)));
         end else begin
            put(UTF8_CONT | 8'($urandom_range(0, 63)));
         end
      end
      n_utf8_seqs++;
   endtask

   task automatic build_stimulus();
      logic [15:0] v;
      logic [7:0]  b;
      int          kind;
      int          target;
      logic [7:0]  simple_esc[8];
      simple_esc = '{jscd_pkg::CH_QUOTE, jscd_pkg::CH_BACKSLASH, jscd_pkg::CH_SLASH,
                     jscd_pkg::CH_B, jscd_pkg::CH_F, jscd_pkg::CH_N, jscd_pkg::CH_R,
                     jscd_pkg::CH_T};
      // extremes, escapes, surrogate with odd digits, stray and long utf-8 leads, clearing
      put(8'h00, 1'b1);
      put(8'h7F);
      put(jscd_pkg::CH_BACKSLASH); put(jscd_pkg::CH_N);
      put(jscd_pkg::CH_BACKSLASH); put(jscd_pkg::CH_QUOTE);
      put(jscd_pkg::CH_BACKSLASH); put(8'h78);
      put(8'h44); put(8'h38); put(8'h33); put(8'h64);
      put(8'hFF); put(jscd_pkg::CH_BACKSLASH);
      put(8'h67); put(8'h47); put(8'h30); put(8'h30);
      put(8'h80); put(8'hC0);
      put(8'hFF); put(jscd_pkg::CH_BACKSLASH); put(8'hBF); put(8'h00);
      put(8'hE2);
      put(8'h41, 1'b1);

      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         if ($urandom_range(0, 19) == 0) begin
            next_sos = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            b = 8'($urandom_range(0, 127));
            put((b == jscd_pkg::CH_BACKSLASH) ? 8'h41 : b);
         end else if (kind < 45) begin
            put(jscd_pkg::CH_BACKSLASH);
            put(simple_esc[3'($urandom_range(0, 7))]);
            n_escapes++;
         end else if (kind < 60) begin
            put(jscd_pkg::CH_BACKSLASH);
            put(($urandom_range(0, 7) == 0) ? odd_escape_letter() : ESC_UNICODE);
            v = 16'($urandom_range(0, 16'hFFFF));
            if (v >= jscd_pkg::HI_SURR_LO && v <= jscd_pkg::HI_SURR_HI) begin
               v = v ^ 16'h4000;
            end
            put_hex4(v, $urandom_range(0, 7) == 0);
            n_escapes++;
         end else if (kind < 72) begin
            put(jscd_pkg::CH_BACKSLASH);
            put(ESC_UNICODE);
            put_hex4(jscd_pkg::HI_SURR_LO + 16'($urandom_range(0, 16'h03FF)), 1'b0);
            if ($urandom_range(0, 5) == 0) begin
               put(8'($urandom_range(0, 255)));
               put(8'($urandom_range(0, 255)));
            end else begin
               put(jscd_pkg::CH_BACKSLASH);
               put(ESC_UNICODE);
            end
            if ($urandom_range(0, 5) == 0) begin
               put_hex4(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
            end else begin
               put_hex4(16'hDC00 + 16'($urandom_range(0, 16'h03FF)), 1'b0);
            end
            n_surr_pairs++;
         end else if (kind < 90) begin
            put_utf8();
         end else if (kind < 95) begin
            put(8'($urandom_range(0, 255)));
         end else begin
            // broken sequence, dropped by a clear on the next byte
            if ($urandom_range(0, 1)) begin
               put(8'hC0 | 8'($urandom_range(0, 63)));
            end else begin
               put(jscd_pkg::CH_BACKSLASH);
               put(ESC_UNICODE);
               put(8'h31);
            end
            next_sos = 1'b1;
         end
      end
      // sender holds this one back until every code point has come out
      pending_bytes[pending_bytes.size() / 2].wait_drain = 1'b1;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
         send_gap <= 0;
      end else begin
         send_gap_n = send_gap;
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.payload.in_byte, req_if.payload.start_of_string);
            void'(pending_bytes.pop_front());
            n_bytes_sent++;
            if ($urandom_range(0, 39) == 0) begin
               src_quiet = !src_quiet;
            end
            send_gap_n = draw_gap(src_quiet);
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap_n != 0 || pending_bytes.size() == 0
                || (pending_bytes[0].wait_drain && predicted_cps.size() != 0)) begin
               req_if.valid <= 1'b0;
               send_gap <= (send_gap_n != 0) ? send_gap_n - 1 : 0;
            end else begin
               req_if.valid <= 1'b1;
               req_if.payload <= pending_bytes[0].data;
               send_gap <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         recv_gap_n = recv_gap;
         if (rsp_if.valid && rsp_if.ready) begin
            n_cps_checked++;
            if (predicted_cps.size() == 0) begin
               flag_error($sformatf("code point %h with nothing predicted",
                                    rsp_if.payload.code_point));
            end else begin
               want_cp = predicted_cps.pop_front();
               if (rsp_if.payload.code_point !== want_cp) begin
                  flag_error($sformatf("code point %h, predicted %h",
                                       rsp_if.payload.code_point, want_cp));
               end
            end
            if ($urandom_range(0, 39) == 0) begin
               snk_quiet = !snk_quiet;
            end
            recv_gap_n = draw_gap(snk_quiet);
         end
         if (long_hold || recv_gap_n != 0) begin
            rsp_if.ready <= 1'b0;
            recv_gap <= (recv_gap_n != 0) ? recv_gap_n - 1 : 0;
         end else begin
            rsp_if.ready <= 1'b1;
            recv_gap <= 0;
         end
      end
   end

   // long result-side stall so the block backs up into its input
   initial begin
      while (n_cps_checked < 150) begin
         @(posedge clock);
      end
      long_hold <= 1'b1;
      repeat (200) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("json_string_codepoint_decoder_core regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      clear_decoder();
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || predicted_cps.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (predicted_cps.size() != 0) begin
         flag_error($sformatf("%0d code points never came out", predicted_cps.size()));
      end
      $display("sent %0d bytes: %0d escapes, %0d surrogate pairs, %0d utf-8 sequences",
               n_bytes_sent, n_escapes, n_surr_pairs, n_utf8_seqs);
      $display("checked %0d code points, %0d mismatches", n_cps_checked, n_errors);
      if (n_errors == 0) begin
         $display("json_string_codepoint_decoder_core regression: pass");
      end else begin
         $display("json_string_codepoint_decoder_core regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/jscd_pkg.sv
sv/jscd_if.sv
sv/json_string_codepoint_decoder_core.sv
test/tb_json_string_codepoint_decoder_core.sv
